// File: rtl/core/hre_pkg.sv
package hre_pkg;

  localparam int unsigned VOLT_W      = 12;
  localparam int unsigned RATE_W      = 11;
  localparam int unsigned SCALE_W     = 6;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned TICK_W      = 6;
  localparam int unsigned PROD_W      = CNT_W + SCALE_W;
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned NUM_W       = 3;
  localparam int unsigned HIST_DEPTH  = 4;
  localparam int unsigned RECIP_W     = 16;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned QUOT_W      = SUM_W + RECIP_W - RECIP_SHIFT;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned CFG_W       = 12;

  localparam logic [TICK_W-1:0]  WINDOW_LAST = 6'd60;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 6'd63;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 11'd2047;

  localparam logic [VOLT_W-1:0]  HIGH_THR_RST   = 12'd2595;
  localparam logic [VOLT_W-1:0]  LOW_THR_RST    = 12'd2565;
  localparam logic [SCALE_W-1:0] BEAT_SCALE_RST = 6'd20;

  typedef enum logic [IDX_W-1:0] {
    REG_HIGH_THR   = 2'd0,
    REG_LOW_THR    = 2'd1,
    REG_BEAT_SCALE = 2'd2
  } hre_reg_e;

  typedef struct packed {
    logic [VOLT_W-1:0]  high_thr;
    logic [VOLT_W-1:0]  low_thr;
    logic [SCALE_W-1:0] beat_scale;
  } hre_cfg_t;

  // window-close sum handed to the divide stage
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [NUM_W-1:0] num;
  } hre_acc_t;

  // divide stage status and history write back
  typedef struct packed {
    logic              busy;
    logic              hist_we;
    logic [RATE_W-1:0] hist_rate;
  } hre_fb_t;

  // 2^15 / n, rounded up; exact floor for sums below 16384
  function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] n);
    logic [RECIP_W-1:0] r;
    unique case (n)
      3'd2:    r = 16'd16384;
      3'd3:    r = 16'd10923;
      3'd4:    r = 16'd8192;
      3'd5:    r = 16'd6554;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/hre_if.sv
interface hre_in_if import hre_pkg::*;;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_mv;

  modport source (output valid, output voltage_mv, input ready);
  modport sink   (input valid, input voltage_mv, output ready);
endinterface

interface hre_out_if import hre_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_bpm;

  modport source (output valid, output rate_bpm, input ready);
  modport sink   (input valid, input rate_bpm, output ready);
endinterface

// File: rtl/core/heart_rate_estimator_unit.sv
// Path: a window-close word shows its result (other words give none) once it
//   has passed the input register, divide stage and output register.
// Throughput: one word per cycle; a window-close word waits in the input
//   register while the previous result still sits in the divide stage.
// Reset (rst_ni, async, active low): detector armed, counters and rate history
//   zero, config back to defaults, all valids low.
module heart_rate_estimator_unit import hre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  hre_in_if.sink           in_i,
  hre_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  hre_cfg_t cfg_q, cfg_d;
  hre_acc_t acc;
  hre_fb_t  fb;

  // config registers; index 3 is ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hre_reg_e'(cfg_idx_i))
        REG_HIGH_THR:   cfg_d.high_thr   = cfg_data_i[VOLT_W-1:0];
        REG_LOW_THR:    cfg_d.low_thr    = cfg_data_i[VOLT_W-1:0];
        REG_BEAT_SCALE: cfg_d.beat_scale = cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr   <= HIGH_THR_RST;
      cfg_q.low_thr    <= LOW_THR_RST;
      cfg_q.beat_scale <= BEAT_SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // stage 1: hysteresis detector, tick counter, window sum
  hre_detect u_detect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .fb_i   (fb),
    .acc_o  (acc)
  );

  // stage 2: average divide, saturate, output word register
  hre_divide u_divide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .fb_o   (fb),
    .out_o  (out_o)
  );

endmodule

// File: rtl/core/hre_detect.sv
module hre_detect import hre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  hre_in_if.sink   in_i,
  input  hre_cfg_t cfg_i,
  input  hre_fb_t  fb_i,
  output hre_acc_t acc_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [VOLT_W-1:0] volt_q;
  logic              armed_q, armed_d;
  logic [CNT_W-1:0]  beat_q, beat_d, beat_inc;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [RATE_W-1:0] hist_q [HIST_DEPTH];

  logic              in_acc, close, beat, rearm, s1_go, run;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [NUM_W-1:0]  num;

  assign in_acc     = in_i.valid && in_i.ready;
  assign close      = (tick_q >= WINDOW_LAST);
  // a closing word needs the divide stage empty so history is current
  assign s1_go      = s1_valid_q && (!close || !fb_i.busy);
  assign in_i.ready = !s1_valid_q || s1_go;

  always_comb begin
    beat  = armed_q && (volt_q >= cfg_i.high_thr);
    rearm = !armed_q && (volt_q <= cfg_i.low_thr);
    beat_inc = (beat && (beat_q != CNT_MAX)) ? beat_q + 1'b1 : beat_q;
    armed_d  = armed_q;
    beat_d   = beat_q;
    tick_d   = tick_q;
    if (s1_go) begin
      if (beat) begin
        armed_d = 1'b0;
      end else if (rearm) begin
        armed_d = 1'b1;
      end
      beat_d = close ? '0 : beat_inc;
      tick_d = close ? '0 : tick_q + 1'b1;
    end
    s1_valid_d = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);
  end

  // scaled count plus leading nonzero history run
  always_comb begin
    prod = beat_inc * cfg_i.beat_scale;
    sum  = SUM_W'(prod);
    num  = NUM_W'(1);
    run  = 1'b1;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      run = run && (hist_q[i] != '0);
      if (run) begin
        sum = sum + SUM_W'(hist_q[i]);
        num = num + 1'b1;
      end
    end
  end

  assign acc_o.valid = s1_go && close;
  assign acc_o.sum   = sum;
  assign acc_o.num   = num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      armed_q    <= 1'b1;
      beat_q     <= '0;
      tick_q     <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      armed_q    <= armed_d;
      beat_q     <= beat_d;
      tick_q     <= tick_d;
      if (fb_i.hist_we) begin
        hist_q[0] <= fb_i.hist_rate;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      volt_q <= in_i.voltage_mv;
    end
  end

  a_tick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= WINDOW_LAST)
    else $error("tick count past window end");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_o.valid |=> (beat_q == '0) && (tick_q == '0))
    else $error("window close did not clear counters");

  a_close_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_o.valid |-> !fb_i.busy && !fb_i.hist_we)
    else $error("window closed while history update pending");

endmodule

// File: rtl/core/hre_divide.sv
module hre_divide import hre_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hre_acc_t acc_i,
  output hre_fb_t  fb_o,
  hre_out_if.source out_o
);

  logic              s2_valid_q, s2_valid_d;
  logic [SUM_W-1:0]  sum_q;
  logic [NUM_W-1:0]  num_q;
  logic              out_valid_q, out_valid_d;
  logic [RATE_W-1:0] rate_q;

  logic                      out_free, s2_go;
  logic [SUM_W+RECIP_W-1:0]  prod;
  logic [QUOT_W-1:0]         quot;
  logic [RATE_W-1:0]         avg;

  assign out_free = !out_valid_q || out_o.ready;
  assign s2_go    = s2_valid_q && out_free;

  // divide by 1..5 as multiply by scaled reciprocal
  always_comb begin
    prod = SUM_W'(sum_q) * recip(num_q);
    quot = prod[SUM_W+RECIP_W-1:RECIP_SHIFT];
    avg  = (quot > QUOT_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
  end

  always_comb begin
    s2_valid_d  = acc_i.valid ? 1'b1 : (s2_go ? 1'b0 : s2_valid_q);
    out_valid_d = s2_go ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  assign fb_o.busy      = s2_valid_q;
  assign fb_o.hist_we   = s2_go;
  assign fb_o.hist_rate = avg;

  assign out_o.valid    = out_valid_q;
  assign out_o.rate_bpm = rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i.valid) begin
      sum_q <= acc_i.sum;
      num_q <= acc_i.num;
    end
    if (s2_go) begin
      rate_q <= avg;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i.valid |-> !s2_valid_q)
    else $error("divide stage overwritten");

  a_hist_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_o.hist_we |=> out_o.valid && (out_o.rate_bpm == $past(avg)))
    else $error("history and output disagree");

endmodule

// File: sim/heart_rate_estimator_unit_tb.sv
module heart_rate_estimator_unit_tb import hre_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;   // two pipeline stages plus margin
  localparam int unsigned PHASE_WORDS   = 330; // about five windows per phase
  localparam int unsigned NUM_PHASES    = 6;
  localparam int unsigned RANDOM_PHASE  = 4;   // thresholds and scale drawn at random

  // index 3 has no register behind it; writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  // Per-phase settings. Phase 0 runs on reset values, the random phase ignores the
  // register columns. Idling: sender 28 / receiver 71, then swapped, then none.
  localparam int unsigned SEND_IDLE_PCT[NUM_PHASES] = '{28, 28, 71, 71, 0, 0};
  localparam int unsigned RECV_STALL_PCT[NUM_PHASES] = '{71, 71, 28, 28, 0, 0};
  localparam int unsigned PULSE_MAX[NUM_PHASES] = '{6, 1, 3, 4, 5, 1};
  localparam logic [CFG_W-1:0] HIGH_SET[NUM_PHASES] = '{2595, 4095, 0, 2048, 0, 2595};
  localparam logic [CFG_W-1:0] LOW_SET[NUM_PHASES] = '{2565, 0, 4095, 2048, 0, 2565};
  localparam logic [CFG_W-1:0] SCALE_SET[NUM_PHASES] = '{20, 63, 0, 1, 0, 63};

  // Bit-exact rate model: hysteresis detector, window counter and the
  // moving average over the leading nonzero run of history.
  class rate_model;
    logic [VOLT_W-1:0]  high_thr;
    logic [VOLT_W-1:0]  low_thr;
    logic [SCALE_W-1:0] scale;
    bit                 armed;
    logic [CNT_W-1:0]   beats;
    logic [TICK_W-1:0]  ticks;
    logic [RATE_W-1:0]  history[HIST_DEPTH];
    logic [RATE_W-1:0]  pending_rates[$];
    int unsigned        mismatches;

    function new();
      high_thr    = HIGH_THR_RST;
      low_thr     = LOW_THR_RST;
      scale       = BEAT_SCALE_RST;
      armed       = 1'b1;
      beats       = '0;
      ticks       = '0;
      mismatches  = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_HIGH_THR:   high_thr = data[VOLT_W-1:0];
        REG_LOW_THR:    low_thr  = data[VOLT_W-1:0];
        REG_BEAT_SCALE: scale    = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted voltage word; queues a rate when it closes the window
    function void take_voltage(logic [VOLT_W-1:0] mv);
      int unsigned sum;
      int unsigned n;
      int unsigned avg;
      // beat test first, re-arm only when no beat was counted
      if (armed && mv >= high_thr) begin
        if (beats != CNT_MAX) beats++;
        armed = 1'b0;
      end else if (!armed && mv <= low_thr) begin
        armed = 1'b1;
      end
      if (ticks == WINDOW_LAST) ticks = '0;
      else ticks++;
      if (ticks != '0) return;
      sum = int'(beats) * int'(scale);
      n   = 1;
      while (n <= HIST_DEPTH && history[n-1] != '0) begin
        sum += history[n-1];
        n++;
      end
      avg = sum / n;
      if (avg > RATE_MAX) avg = RATE_MAX;
      for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = avg[RATE_W-1:0];
      beats = '0;
      pending_rates.push_back(avg[RATE_W-1:0]);
    endfunction

    function void check_rate(logic [RATE_W-1:0] actual);
      logic [RATE_W-1:0] expected;
      if (pending_rates.size() == 0) begin
        $error("rate_bpm: no word expected, actual %0d", actual);
        mismatches++;
        return;
      end
      expected = pending_rates.pop_front();
      if (actual !== expected) begin
        $error("rate_bpm: expected %0d, actual %0d", expected, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  hre_in_if  in_if();
  hre_out_if out_if();

  rate_model   rates = new();
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned pulse_max;
  int unsigned cycles;
  // waveform generator state: current segment level and ticks left in it
  bit          seg_high;
  int unsigned seg_left;

  heart_rate_estimator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a lost word or a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, one ready update per edge.
  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result check: values sampled here are the ones the edge itself saw.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) rates.check_rate(out_if.rate_bpm);
  end

  // Drives one voltage word and holds it until accepted. Leaves valid high so a
  // back-to-back word needs no extra assignment in the same step.
  task automatic send_word(input logic [VOLT_W-1:0] mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.voltage_mv <= mv;
    do @(posedge clk_i); while (!in_if.ready);
    rates.take_voltage(mv);
  endtask

  // Holds the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    rates.apply_reg(idx, data);
  endtask

  // Every expected rate is in, then a few cycles for words that close no window
  // but may still sit in the input register.
  task automatic wait_idle();
    while (rates.pending_rates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly pulse trains around the thresholds (narrow pulses give the maximum
  // beat rate), plus raw noise and values at and just inside the thresholds.
  function automatic logic [VOLT_W-1:0] next_voltage();
    int unsigned pick;
    logic [VOLT_W-1:0] mv;
    pick = $urandom_range(99);
    if (pick < 12) begin
      mv = VOLT_W'($urandom_range(4095));
    end else if (pick < 18) begin
      case ($urandom_range(3))
        0: mv = rates.high_thr;
        1: mv = rates.high_thr - 1'b1;
        2: mv = rates.low_thr;
        default: mv = rates.low_thr + 1'b1;
      endcase
    end else begin
      if (seg_left == 0) begin
        seg_high = !seg_high;
        seg_left = $urandom_range(pulse_max, 1);
      end
      seg_left--;
      if ($urandom_range(3) == 0) mv = seg_high ? rates.high_thr : rates.low_thr;
      else if (seg_high) mv = VOLT_W'($urandom_range(4095, rates.high_thr));
      else mv = VOLT_W'($urandom_range(rates.low_thr, 0));
    end
    return mv;
  endfunction

  // Directed words on reset thresholds (high 2595, low 2565): just below and at
  // the beat level, held high while disarmed, just above and at the re-arm
  // level, the field extremes and single-bit patterns.
  logic [VOLT_W-1:0] directed_mv[$] = '{
    12'd0, 12'd4095, 12'd2594, 12'd2595, 12'd4095, 12'd2566, 12'd2565, 12'd2566,
    12'd2595, 12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd2565, 12'd2596, 12'd1,
    12'd2, 12'd4, 12'd8, 12'd2048, 12'd4095, 12'd0
  };

  initial begin
    rst_ni           = 1'b0;
    cycles           = 0;
    in_if.valid      = 1'b0;
    in_if.voltage_mv = '0;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    seg_high         = 1'b0;
    seg_left         = 0;
    send_idle_pct    = SEND_IDLE_PCT[0];
    recv_stall_pct   = RECV_STALL_PCT[0];
    pulse_max        = PULSE_MAX[0];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      pulse_max      = PULSE_MAX[ph];
      if (ph == 0) begin
        foreach (directed_mv[i]) send_word(directed_mv[i]);
      end else begin
        // block drained: safe to retune. Phases cover extreme, crossed and
        // equal thresholds, zero scale (zeros into history) and full scale
        // with maximum beat rate (largest sums).
        wait_idle();
        if (ph == RANDOM_PHASE) begin
          write_reg(REG_HIGH_THR, CFG_W'($urandom_range(4095)));
          write_reg(REG_LOW_THR, CFG_W'($urandom_range(4095)));
          write_reg(REG_BEAT_SCALE, CFG_W'($urandom_range(4095)));
          write_reg(REG_SPARE, CFG_W'($urandom_range(4095)));
        end else begin
          write_reg(REG_HIGH_THR, HIGH_SET[ph]);
          write_reg(REG_LOW_THR, LOW_SET[ph]);
          write_reg(REG_BEAT_SCALE, SCALE_SET[ph]);
        end
        cfg_we <= 1'b0;
      end
      repeat (PHASE_WORDS) send_word(next_voltage());
      in_if.valid <= 1'b0;
    end

    wait_idle();
    if (rates.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
